// ----- src/ptot_pkg.sv -----
package ptot_pkg;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_HITS_PER_TICK = 64;
  localparam int DEF_TICK_BITS = 32;

  localparam int CHG_W = 24;
  localparam int CFG_W = 24;
  localparam int DIV_STEPS = CHG_W;

  localparam logic [1:0] ACT_DEPOSIT = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;
  localparam logic [1:0] ACT_CLEAR   = 2'd3;

  localparam logic [2:0] ST_OFF      = 3'd0;
  localparam logic [2:0] ST_START    = 3'd1;
  localparam logic [2:0] ST_ON       = 3'd2;
  localparam logic [2:0] ST_READY    = 3'd3;
  localparam logic [2:0] ST_OOB      = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  localparam logic [1:0] CFG_THRESHOLD       = 2'd0;
  localparam logic [1:0] CFG_CHARGE_PER_TICK = 2'd1;
  localparam logic [1:0] CFG_ROWS_IN_USE     = 2'd2;
  localparam logic [1:0] CFG_COLS_IN_USE     = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [23:0] charge;
  } item_t;

  typedef struct packed {
    logic [2:0]  pixel_state;
    logic [31:0] start_tick;
    logic [31:0] tot_ticks;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SWEEP_ALL,
    OP_SWEEP_REC,
    OP_PIX_RD,
    OP_OOB,
    OP_DEP_EXE,
    OP_RD_EXE,
    OP_ZERO,
    OP_TICK_INC,
    OP_LIST_RD,
    OP_TPIX_RD,
    OP_TPIX_EXE,
    OP_DIV_STEP,
    OP_TPIX_WB,
    OP_TICK_END
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       oob;
    logic       sweep_last;
    logic       list_end;
    logic       div_need;
    logic       div_last;
  } status_t;

  function automatic logic [CHG_W-1:0] sat_add(input logic [CHG_W-1:0] a,
                                               input logic [CHG_W-1:0] b);
    logic [CHG_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CHG_W] ? {CHG_W{1'b1}} : s[CHG_W-1:0];
  endfunction

endpackage

// ----- src/ptot_ctrl.sv -----
module ptot_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ptot_pkg::status_t status,
  output ptot_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PIX_RD, S_DEP, S_RD, S_CLR, S_CLR_END,
    S_TICK_INC, S_LIST, S_TADDR, S_TDATA, S_DIV, S_WB
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.load = 1'b0;
    cmd.op = ptot_pkg::OP_NONE;
    unique case (state)
      S_INIT: begin
        cmd.op = ptot_pkg::OP_SWEEP_ALL;
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_PIX_RD;
        end
      end
      S_PIX_RD: begin
        // dispatch on the latched action
        unique case (status.action)
          ptot_pkg::ACT_TICK: state_next = S_TICK_INC;
          ptot_pkg::ACT_CLEAR: state_next = S_CLR;
          default: begin
            if (status.oob) begin
              cmd.op = ptot_pkg::OP_OOB;
              state_next = S_IDLE;
            end else begin
              cmd.op = ptot_pkg::OP_PIX_RD;
              state_next = (status.action == ptot_pkg::ACT_DEPOSIT) ? S_DEP : S_RD;
            end
          end
        endcase
      end
      S_DEP: begin
        cmd.op = ptot_pkg::OP_DEP_EXE;
        state_next = S_IDLE;
      end
      S_RD: begin
        cmd.op = ptot_pkg::OP_RD_EXE;
        state_next = S_IDLE;
      end
      S_CLR: begin
        cmd.op = ptot_pkg::OP_SWEEP_REC;
        if (status.sweep_last) state_next = S_CLR_END;
      end
      S_CLR_END: begin
        cmd.op = ptot_pkg::OP_ZERO;
        state_next = S_IDLE;
      end
      S_TICK_INC: begin
        cmd.op = ptot_pkg::OP_TICK_INC;
        state_next = S_LIST;
      end
      S_LIST: begin
        if (status.list_end) begin
          cmd.op = ptot_pkg::OP_TICK_END;
          state_next = S_IDLE;
        end else begin
          cmd.op = ptot_pkg::OP_LIST_RD;
          state_next = S_TADDR;
        end
      end
      S_TADDR: begin
        cmd.op = ptot_pkg::OP_TPIX_RD;
        state_next = S_TDATA;
      end
      S_TDATA: begin
        cmd.op = ptot_pkg::OP_TPIX_EXE;
        state_next = status.div_need ? S_DIV : S_LIST;
      end
      S_DIV: begin
        cmd.op = ptot_pkg::OP_DIV_STEP;
        if (status.div_last) state_next = S_WB;
      end
      S_WB: begin
        cmd.op = ptot_pkg::OP_TPIX_WB;
        state_next = S_LIST;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      busy <= 1'b1;
    end else begin
      state <= state_next;
      busy <= (state_next != S_IDLE);
    end
  end

endmodule

// ----- src/ptot_datapath.sv -----
module ptot_datapath #(
  parameter int MAX_ROWS = ptot_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ptot_pkg::DEF_MAX_COLS,
  parameter int MAX_HITS_PER_TICK = ptot_pkg::DEF_MAX_HITS_PER_TICK,
  parameter int TICK_BITS = ptot_pkg::DEF_TICK_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ptot_pkg::item_t          item,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [ptot_pkg::CFG_W-1:0] cfg_wdata,
  input  ptot_pkg::cmd_t           cmd,
  output ptot_pkg::status_t        status,
  output logic                     result_valid,
  output ptot_pkg::result_t        result
);

  localparam int NPIX = MAX_ROWS * MAX_COLS;
  localparam int PW = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int HW = (MAX_HITS_PER_TICK > 1) ? $clog2(MAX_HITS_PER_TICK) : 1;
  localparam int CW = $clog2(MAX_HITS_PER_TICK + 1);
  localparam int TB = TICK_BITS;
  localparam int EW = ((TB > ptot_pkg::CHG_W + 1) ? TB : ptot_pkg::CHG_W + 1) + 1;
  localparam int XW = TB + 32;
  localparam int CH = ptot_pkg::CHG_W;

  // config
  logic [CH-1:0] threshold, charge_per_tick;
  logic [8:0] rows_in_use, cols_in_use;

  ptot_pkg::item_t item_q;
  logic [TB-1:0] tick;
  logic [CW-1:0] hit_cnt, idx;
  logic [PW-1:0] sweep_cnt, pix;
  logic [CH-1:0] chg_hold;
  logic [TB-1:0] first_hold;
  logic [CH-1:0] div_rem, div_quo, div_d;
  logic [4:0] div_step;

  // memories and read data
  logic live_mem [NPIX];
  logic [CH-1:0] acc_mem [NPIX];
  logic [TB-1:0] first_mem [NPIX];
  logic [TB-1:0] last_mem [NPIX];
  logic [CH:0] pend_mem [NPIX];
  logic [PW-1:0] list_mem [MAX_HITS_PER_TICK];

  logic live_q;
  logic [CH-1:0] acc_q;
  logic [TB-1:0] first_q, last_q;
  logic [CH:0] pend_q;
  logic [PW-1:0] list_q;

  logic [PW-1:0] item_pix, rd_addr, wr_addr;
  logic row_ok, col_ok, oob;
  logic live_we, live_wd, acc_we, tick_we, pend_we, list_we;
  logic [CH:0] pend_wd;
  logic [CH-1:0] acc_wd, chg_new, dvs;
  logic [TB-1:0] end_tick;
  logic live_now, need, touched, full, sweeping;
  logic [CH:0] rem_w;
  logic rem_ge;
  logic [CH:0] len;
  logic [EW-1:0] end_sum;
  logic [XW-1:0] first_x, tot_x;
  ptot_pkg::result_t view;
  logic result_valid_next;
  ptot_pkg::result_t result_next;

  assign row_ok = ({1'b0, item_q.row} < rows_in_use) && (32'(item_q.row) < 32'(MAX_ROWS));
  assign col_ok = ({1'b0, item_q.col} < cols_in_use) && (32'(item_q.col) < 32'(MAX_COLS));
  assign oob = !(row_ok && col_ok);
  assign item_pix = PW'(32'(item_q.row) * 32'(MAX_COLS) + 32'(item_q.col));
  assign rd_addr = (cmd.op == ptot_pkg::OP_TPIX_RD) ? list_q : item_pix;
  assign sweeping = (cmd.op == ptot_pkg::OP_SWEEP_ALL) || (cmd.op == ptot_pkg::OP_SWEEP_REC);
  assign wr_addr = sweeping ? sweep_cnt : pix;

  assign live_now = live_q && (last_q >= tick);
  assign touched = pend_q[CH];
  assign full = !touched && (32'(hit_cnt) >= 32'(MAX_HITS_PER_TICK));
  assign chg_new = live_now ? ptot_pkg::sat_add(acc_q, pend_q[CH-1:0]) : pend_q[CH-1:0];
  assign need = chg_new > threshold;
  assign dvs = (charge_per_tick == '0) ? CH'(1) : charge_per_tick;

  // restoring divider, one quotient bit a step
  assign rem_w = {div_rem, div_quo[CH-1]};
  assign rem_ge = rem_w >= {1'b0, div_d};

  // ceil from floor plus a nonzero remainder
  assign len = {1'b0, div_quo} + (CH+1)'(div_rem != '0);
  assign end_sum = EW'(first_hold) + EW'(len);
  assign end_tick = (end_sum > EW'({TB{1'b1}})) ? {TB{1'b1}} : end_sum[TB-1:0];

  assign first_x = XW'(first_q);
  assign tot_x = XW'(last_q - first_q);

  always_comb begin
    view = '0;
    if (live_now) begin
      view.start_tick = first_x[31:0];
      if (first_q == tick) view.pixel_state = ptot_pkg::ST_START;
      else if (last_q == tick) begin
        view.pixel_state = ptot_pkg::ST_READY;
        view.tot_ticks = tot_x[31:0];
      end else view.pixel_state = ptot_pkg::ST_ON;
    end
  end

  // result beat for the current step
  always_comb begin
    result_valid_next = 1'b0;
    result_next = '0;
    case (cmd.op)
      ptot_pkg::OP_OOB: begin
        result_valid_next = 1'b1;
        result_next.pixel_state = ptot_pkg::ST_OOB;
      end
      ptot_pkg::OP_DEP_EXE: begin
        result_valid_next = 1'b1;
        if (full) result_next.pixel_state = ptot_pkg::ST_OVERFLOW;
        else result_next = view;
      end
      ptot_pkg::OP_RD_EXE: begin
        result_valid_next = 1'b1;
        result_next = view;
      end
      ptot_pkg::OP_ZERO: result_valid_next = 1'b1;
      ptot_pkg::OP_TICK_END: result_valid_next = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    live_we = 1'b0;
    live_wd = 1'b0;
    acc_we = 1'b0;
    acc_wd = chg_new;
    tick_we = 1'b0;
    pend_we = 1'b0;
    pend_wd = '0;
    list_we = 1'b0;
    case (cmd.op)
      ptot_pkg::OP_SWEEP_ALL: begin
        live_we = 1'b1;
        pend_we = 1'b1;
      end
      ptot_pkg::OP_SWEEP_REC: live_we = 1'b1;
      ptot_pkg::OP_DEP_EXE: begin
        if (!full) begin
          pend_we = 1'b1;
          pend_wd = {1'b1, ptot_pkg::sat_add(pend_q[CH-1:0], item_q.charge)};
          list_we = !touched;
        end
      end
      ptot_pkg::OP_TPIX_EXE: begin
        pend_we = 1'b1;
        acc_we = live_now && !need;
      end
      ptot_pkg::OP_TPIX_WB: begin
        live_we = 1'b1;
        live_wd = 1'b1;
        acc_we = 1'b1;
        acc_wd = chg_hold;
        tick_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    live_q <= live_mem[rd_addr];
    acc_q <= acc_mem[rd_addr];
    first_q <= first_mem[rd_addr];
    last_q <= last_mem[rd_addr];
    pend_q <= pend_mem[rd_addr];
    list_q <= list_mem[idx[HW-1:0]];
    if (live_we) live_mem[wr_addr] <= live_wd;
    if (acc_we) acc_mem[wr_addr] <= acc_wd;
    if (tick_we) begin
      first_mem[wr_addr] <= first_hold;
      last_mem[wr_addr] <= end_tick;
    end
    if (pend_we) pend_mem[wr_addr] <= pend_wd;
    if (list_we) list_mem[hit_cnt[HW-1:0]] <= pix;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_q <= item;
    if (cmd.op == ptot_pkg::OP_PIX_RD) pix <= item_pix;
    if (cmd.op == ptot_pkg::OP_TPIX_RD) pix <= list_q;
    if (cmd.op == ptot_pkg::OP_TPIX_EXE) begin
      chg_hold <= chg_new;
      first_hold <= live_now ? first_q : tick;
      div_rem <= '0;
      div_quo <= chg_new - threshold;
      div_d <= dvs;
    end
    if (cmd.op == ptot_pkg::OP_DIV_STEP) begin
      div_rem <= rem_ge ? CH'(rem_w - {1'b0, div_d}) : rem_w[CH-1:0];
      div_quo <= {div_quo[CH-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      charge_per_tick <= CH'(1);
      rows_in_use <= 9'd256;
      cols_in_use <= 9'd256;
      tick <= '0;
      hit_cnt <= '0;
      idx <= '0;
      sweep_cnt <= '0;
      div_step <= '0;
      result_valid <= 1'b0;
      result <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ptot_pkg::CFG_THRESHOLD: threshold <= cfg_wdata;
          ptot_pkg::CFG_CHARGE_PER_TICK: charge_per_tick <= cfg_wdata;
          ptot_pkg::CFG_ROWS_IN_USE: rows_in_use <= cfg_wdata[8:0];
          ptot_pkg::CFG_COLS_IN_USE: cols_in_use <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      result_valid <= result_valid_next;
      result <= result_next;
      if (sweeping) sweep_cnt <= status.sweep_last ? '0 : sweep_cnt + PW'(1);
      case (cmd.op)
        ptot_pkg::OP_DEP_EXE: begin
          if (!full && !touched) hit_cnt <= hit_cnt + CW'(1);
        end
        ptot_pkg::OP_TICK_INC: begin
          tick <= tick + TB'(1);
          idx <= '0;
        end
        ptot_pkg::OP_TPIX_EXE: begin
          div_step <= '0;
          if (!need) idx <= idx + CW'(1);
        end
        ptot_pkg::OP_DIV_STEP: div_step <= div_step + 5'd1;
        ptot_pkg::OP_TPIX_WB: idx <= idx + CW'(1);
        ptot_pkg::OP_TICK_END: hit_cnt <= '0;
        default: ;
      endcase
    end
  end

  assign status.action = item_q.action;
  assign status.oob = oob;
  assign status.sweep_last = (sweep_cnt == PW'(NPIX - 1));
  assign status.list_end = (idx == hit_cnt);
  assign status.div_need = need;
  assign status.div_last = (div_step == 5'(ptot_pkg::DIV_STEPS - 1));

endmodule

// ----- src/pixel_time_over_threshold_matrix_top.sv -----
// time over threshold pixel matrix: start is taken when busy is low, and
// every item yields exactly one result beat, shown on result for a single
// cycle while result_valid is high; the receiver cannot stall it, so it must
// take the beat in that cycle. a deposit or read steps through accept,
// pixel memory read and update before the next accept, and skips the update
// when the pixel is out of bounds; its beat shows in the cycle after the
// last step, when busy is already low. a clear item sweeps the live flags,
// one pixel a cycle. a tick increments the tick counter, then for each pixel
// hit since the last tick reads the hit list and the pixel memories; when
// the pixel's charge is over threshold, the 24 step serial divider computes
// the over-threshold length before the write back. after reset, busy stays
// high while the live flags and the pending charges are swept clear;
// configuration writes are taken at any time, meant for idle periods
module pixel_time_over_threshold_matrix_top #(
  parameter int MAX_ROWS = ptot_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ptot_pkg::DEF_MAX_COLS,
  parameter int MAX_HITS_PER_TICK = ptot_pkg::DEF_MAX_HITS_PER_TICK,
  parameter int TICK_BITS = ptot_pkg::DEF_TICK_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  // item channel
  input  logic                       start,
  output logic                       busy,
  input  ptot_pkg::item_t            item,
  // register writes
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [ptot_pkg::CFG_W-1:0] cfg_wdata,
  // result beats
  output logic                       result_valid,
  output ptot_pkg::result_t          result
);

  ptot_pkg::cmd_t    cmd;
  ptot_pkg::status_t status;

  // sequencer: decides the memory step for each cycle
  ptot_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // pixel memories, hit list, tick counter and divider
  ptot_datapath #(
    .MAX_ROWS          (MAX_ROWS),
    .MAX_COLS          (MAX_COLS),
    .MAX_HITS_PER_TICK (MAX_HITS_PER_TICK),
    .TICK_BITS         (TICK_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
